/* src/ttss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttss_pkg
// Shared types and sizing for the thread table scheduler with semaphores.
// ----------------------------------------------------------------------------
package ttss_pkg;

  localparam int THREAD_SLOTS = 16;
  localparam int SEM_COUNT    = 16;
  localparam int COUNT_BITS   = 16;

  localparam int SLOT_W     = $clog2(THREAD_SLOTS + 1);
  localparam int SLOT_IDX_W = $clog2(THREAD_SLOTS);
  localparam int SEM_IDX_W  = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
  localparam int SEM_ID_W   = 4;

  typedef enum logic [2:0] {
    OP_CREATE   = 3'd0,
    OP_TEARDOWN = 3'd1,
    OP_SCHEDULE = 3'd2,
    OP_INIT_SEM = 3'd3,
    OP_WAIT_SEM = 3'd4,
    OP_POST_SEM = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TABLE_FULL  = 3'd1,
    ST_SLOT_EMPTY  = 3'd2,
    ST_BLOCKED     = 3'd3,
    ST_NO_RUNNABLE = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    FSM_IDLE = 4'b0001,
    FSM_EXEC = 4'b0010,
    FSM_SCAN = 4'b0100,
    FSM_RESP = 4'b1000
  } fsm_e;

  typedef enum logic [1:0] {
    MATCH_FREE     = 2'd0,
    MATCH_RUNNABLE = 2'd1,
    MATCH_SLEEPER  = 2'd2
  } match_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  thread_id;
    logic [3:0]  sem_id;
    logic [15:0] init_value;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] result_thread;
    logic [4:0] woken_thread;
  } rsp_t;

  typedef struct packed {
    logic                load;
    logic                run;
    match_e              mode;
    logic [SEM_ID_W-1:0] sem;
  } scan_t;

  typedef struct packed {
    logic                we;
    logic                occupied;
    logic                sleeping;
    logic [SEM_ID_W-1:0] wait_sem;
  } upd_t;

endpackage

/* src/thread_table_scheduler_semaphores_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_table_scheduler_semaphores_core
// Thread table with round-robin scheduler and counting semaphores.
//
// Requests enter on in_req_i (valid/stall) and each one returns exactly one
// response on out_rsp_o (valid/stall), in order. One request is worked on at
// a time; in_stall_o is low only while the block is idle.
// Teardown, semaphore init and wait, a schedule that keeps the current thread
// and undefined ops go from the execute state straight to the response state.
// Create, a post to a valid semaphore and a schedule that must search pass
// through the scan state in between: a token walks the ring of slot cells one
// cell per cycle until the first matching slot, and a full search visits all
// THREAD_SLOTS cells.
// The response register lets the next request start while a response is
// still stalled; the block only waits at its last step if the previous
// response has not been taken.
// Reset empties the table, clears all semaphore counts and leaves no
// current thread; the block accepts requests in the first cycle after reset.
// ----------------------------------------------------------------------------
module thread_table_scheduler_semaphores_core
  import ttss_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  localparam int EXT_W  = SLOT_W + 5;
  localparam int SIDX_W = SEM_IDX_W + SEM_ID_W;

  fsm_e                  state_q, state_d;
  req_t                  req_q;
  rsp_t                  rsp_q, rsp_d;
  rsp_t                  out_q;
  logic                  out_valid_q, out_valid_d;
  logic [SLOT_IDX_W-1:0] step_q, step_d;
  logic [SLOT_W-1:0]     cur_q, cur_d;
  logic [COUNT_BITS-1:0] sem_q [SEM_COUNT];

  logic                  sem_we;
  logic [COUNT_BITS-1:0] sem_wdata;

  scan_t                   scan;
  upd_t                    upd;
  logic [THREAD_SLOTS-1:0] sel_vec, start_vec, tok_vec, hit_vec, occ_vec, slp_vec;

  logic [SIDX_W-1:0]     sid_w;
  logic [SEM_IDX_W-1:0]  sem_idx;
  logic                  sem_ok;
  logic [COUNT_BITS-1:0] cnt;
  logic [EXT_W-1:0]      tid_x, cur_x;
  logic [SLOT_IDX_W-1:0] tid_idx, cur_idx, start_idx, hit_idx;
  logic                  tid_ok, cur_occ, cur_run;
  logic [SLOT_W-1:0]     hit_slot;
  logic                  resp_go;

  // slot ring
  for (genvar g = 0; g < THREAD_SLOTS; g++) begin : g_cell
    ttss_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tok_i      (tok_vec[(g + THREAD_SLOTS - 1) % THREAD_SLOTS]),
      .start_i    (start_vec[g]),
      .scan_i     (scan),
      .sel_i      (sel_vec[g]),
      .upd_i      (upd),
      .tok_o      (tok_vec[g]),
      .hit_o      (hit_vec[g]),
      .occupied_o (occ_vec[g]),
      .sleeping_o (slp_vec[g])
    );
  end

  always_comb begin
    sid_w   = SIDX_W'(req_q.sem_id);
    sem_idx = sid_w[SEM_IDX_W-1:0];
    sem_ok  = sid_w < SIDX_W'(SEM_COUNT);
    cnt     = sem_q[sem_idx];
    tid_x   = EXT_W'(req_q.thread_id) - EXT_W'(1);
    tid_idx = tid_x[SLOT_IDX_W-1:0];
    tid_ok  = (req_q.thread_id != '0) &&
              (EXT_W'(req_q.thread_id) <= EXT_W'(THREAD_SLOTS));
    cur_x   = EXT_W'(cur_q) - EXT_W'(1);
    cur_idx = cur_x[SLOT_IDX_W-1:0];
    cur_occ = (cur_q != '0) && occ_vec[cur_idx];
    cur_run = cur_occ && !slp_vec[cur_idx];
    if (cur_q == '0 || cur_q == SLOT_W'(THREAD_SLOTS)) begin
      start_idx = '0;
    end else begin
      start_idx = cur_q[SLOT_IDX_W-1:0];
    end
  end

  // one-hot hit to slot index
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < THREAD_SLOTS; i++) begin
      if (hit_vec[i]) begin
        hit_idx = hit_idx | SLOT_IDX_W'(i);
      end
    end
    hit_slot = SLOT_W'(hit_idx) + SLOT_W'(1);
  end

  assign resp_go = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    rsp_d     = rsp_q;
    step_d    = step_q;
    cur_d     = cur_q;
    sem_we    = 1'b0;
    sem_wdata = cnt;
    scan      = '0;
    upd       = '0;
    sel_vec   = '0;
    start_vec = '0;
    scan.sem  = req_q.sem_id;
    case (req_q.op)
      OP_SCHEDULE: scan.mode = MATCH_RUNNABLE;
      OP_POST_SEM: scan.mode = MATCH_SLEEPER;
      default:     scan.mode = MATCH_FREE;
    endcase

    case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) begin
          state_d = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        rsp_d   = '0;
        step_d  = '0;
        state_d = FSM_RESP;
        case (req_q.op)
          OP_CREATE: begin
            scan.load    = 1'b1;
            start_vec[0] = 1'b1;
            state_d      = FSM_SCAN;
          end
          OP_TEARDOWN: begin
            if (tid_ok && occ_vec[tid_idx]) begin
              upd.we           = 1'b1;
              sel_vec[tid_idx] = 1'b1;
            end else begin
              rsp_d.status = ST_SLOT_EMPTY;
            end
          end
          OP_SCHEDULE: begin
            if (cur_run) begin
              rsp_d.result_thread = 5'(cur_q);
            end else begin
              scan.load            = 1'b1;
              start_vec[start_idx] = 1'b1;
              state_d              = FSM_SCAN;
            end
          end
          OP_INIT_SEM: begin
            if (sem_ok) begin
              sem_we    = 1'b1;
              sem_wdata = COUNT_BITS'(req_q.init_value);
            end
          end
          OP_WAIT_SEM: begin
            if (sem_ok) begin
              if (cnt != '0) begin
                sem_we    = 1'b1;
                sem_wdata = cnt - COUNT_BITS'(1);
              end else if (cur_occ) begin
                upd.we           = 1'b1;
                upd.occupied     = 1'b1;
                upd.sleeping     = 1'b1;
                upd.wait_sem     = req_q.sem_id;
                sel_vec[cur_idx] = 1'b1;
                rsp_d.status     = ST_BLOCKED;
              end else begin
                rsp_d.status = ST_SLOT_EMPTY;
              end
            end
          end
          OP_POST_SEM: begin
            if (sem_ok) begin
              sem_we = 1'b1;
              if (cnt != '1) begin
                sem_wdata = cnt + COUNT_BITS'(1);
              end
              scan.load    = 1'b1;
              start_vec[0] = 1'b1;
              state_d      = FSM_SCAN;
            end
          end
          default: ;
        endcase
      end
      FSM_SCAN: begin
        scan.run = 1'b1;
        if (|hit_vec) begin
          state_d = FSM_RESP;
          case (req_q.op)
            OP_CREATE: begin
              upd.we              = 1'b1;
              upd.occupied        = 1'b1;
              sel_vec             = hit_vec;
              rsp_d.result_thread = 5'(hit_slot);
            end
            OP_SCHEDULE: begin
              cur_d               = hit_slot;
              rsp_d.result_thread = 5'(hit_slot);
            end
            default: begin
              upd.we             = 1'b1;
              upd.occupied       = 1'b1;
              sel_vec            = hit_vec;
              rsp_d.woken_thread = 5'(hit_slot);
            end
          endcase
        end else if (step_q == SLOT_IDX_W'(THREAD_SLOTS - 1)) begin
          state_d = FSM_RESP;
          case (req_q.op)
            OP_CREATE:   rsp_d.status = ST_TABLE_FULL;
            OP_SCHEDULE: rsp_d.status = ST_NO_RUNNABLE;
            default:     rsp_d.status = ST_OK;
          endcase
        end else begin
          step_d = step_q + SLOT_IDX_W'(1);
        end
      end
      FSM_RESP: begin
        if (resp_go) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == FSM_RESP && resp_go) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      cur_q       <= '0;
      for (int i = 0; i < SEM_COUNT; i++) begin
        sem_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      cur_q       <= cur_d;
      if (sem_we) begin
        sem_q[sem_idx] <= sem_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FSM_IDLE && in_valid_i) begin
      req_q <= in_req_i;
    end
    rsp_q <= rsp_d;
    if (state_q == FSM_RESP && resp_go) begin
      out_q <= rsp_q;
    end
  end

  assign in_stall_o  = (state_q != FSM_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_hit_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("more than one slot matched in one scan step");

  a_token_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_SCAN |-> $onehot(tok_vec))
    else $error("scan token lost or duplicated");

  a_token_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_IDLE |-> tok_vec == '0)
    else $error("scan token left in ring while idle");

  a_sleep_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slp_vec & ~occ_vec) == '0)
    else $error("free slot marked sleeping");

  a_current_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= SLOT_W'(THREAD_SLOTS))
    else $error("current slot out of range");

endmodule

/* src/ttss_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttss_cell
// One thread slot of the ring: slot state plus a scan token handed to the
// next cell every cycle while a search runs.
// ----------------------------------------------------------------------------
module ttss_cell
  import ttss_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  tok_i,
  input  logic  start_i,
  input  scan_t scan_i,
  input  logic  sel_i,
  input  upd_t  upd_i,
  output logic  tok_o,
  output logic  hit_o,
  output logic  occupied_o,
  output logic  sleeping_o
);

  logic                occ_q, occ_d;
  logic                slp_q, slp_d;
  logic [SEM_ID_W-1:0] wsem_q, wsem_d;
  logic                tok_q, tok_d;
  logic                match;

  always_comb begin
    occ_d  = occ_q;
    slp_d  = slp_q;
    wsem_d = wsem_q;
    if (upd_i.we && sel_i) begin
      occ_d  = upd_i.occupied;
      slp_d  = upd_i.sleeping;
      wsem_d = upd_i.wait_sem;
    end
  end

  always_comb begin
    if (scan_i.load) begin
      tok_d = start_i;
    end else if (scan_i.run) begin
      tok_d = tok_i;
    end else begin
      tok_d = 1'b0;
    end
  end

  always_comb begin
    case (scan_i.mode)
      MATCH_FREE:     match = !occ_q;
      MATCH_RUNNABLE: match = occ_q && !slp_q;
      MATCH_SLEEPER:  match = occ_q && slp_q && (wsem_q == scan_i.sem);
      default:        match = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= 1'b0;
      slp_q  <= 1'b0;
      wsem_q <= '0;
      tok_q  <= 1'b0;
    end else begin
      occ_q  <= occ_d;
      slp_q  <= slp_d;
      wsem_q <= wsem_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o      = tok_q;
  assign hit_o      = tok_q && scan_i.run && match;
  assign occupied_o = occ_q;
  assign sleeping_o = slp_q;

endmodule
